### rtl/core/hrhc_pkg.sv
// Shared types, constants and a helper function for the HTTP request head checker.
package hrhc_pkg;

   localparam int FIFO_DEPTH = 4;

   localparam logic [15:0] BYTE_LIMIT_RESET = 16'd2045;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_BAD  = 2'd1;
   localparam logic [1:0] ST_NIMP = 2'd2;

   localparam logic [1:0] METHOD_GET  = 2'd0;
   localparam logic [1:0] METHOD_HEAD = 2'd1;
   localparam logic [1:0] METHOD_PUT  = 2'd2;

   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_PLUS  = 8'h2B;

   localparam int DATA_W   = 8;
   localparam int STATUS_W = 2;
   localparam int METHOD_W = 2;
   localparam int LENGTH_W = 31;
   localparam int SIZE_W   = 16;
   localparam int RSP_W    = 56;

   // Classified input beat handed from the front end to the parser.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_start;
      logic       crlf;
      logic       prev_cr;
      logic       prev_colon;
      logic       prev2_colon;
      logic       over_cur;
      logic       over_prev;
   } entry_type;

   function automatic logic [15:0] sat16_add(logic [15:0] v, logic [1:0] d);
      logic [16:0] s;
      s = {1'b0, v} + {15'b0, d};
      return s[16] ? 16'hFFFF : s[15:0];
   endfunction

endpackage

### rtl/core/hrhc_front.sv
// Front end: accepts input beats, tracks position and recent bytes, classifies each beat.
module hrhc_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [15:0]         csr_write_data,
   input  logic [7:0]          data_byte,
   input  logic                frame_start,
   input  logic                push,
   output hrhc_pkg::entry_type entry
);
   import hrhc_pkg::*;

   logic [15:0] byte_limit_ff, byte_limit_in;
   logic [15:0] pos_ff, pos_in;
   logic [7:0]  prev_ff, prev_in;
   logic [7:0]  prev2_ff, prev2_in;
   logic [15:0] cur_pos;
   logic [15:0] cur_pos_m1;
   logic [7:0]  cur_prev;
   logic [7:0]  cur_prev2;

   always_comb begin
      cur_pos    = frame_start ? 16'd0 : pos_ff;
      cur_prev   = frame_start ? 8'd0 : prev_ff;
      cur_prev2  = frame_start ? 8'd0 : prev2_ff;
      cur_pos_m1 = (cur_pos == 16'd0) ? 16'd0 : cur_pos - 16'd1;

      entry.data_byte   = data_byte;
      entry.frame_start = frame_start;
      entry.crlf        = (data_byte == CH_LF) && (cur_prev == CH_CR);
      entry.prev_cr     = (cur_prev == CH_CR);
      entry.prev_colon  = (cur_prev == CH_COLON);
      entry.prev2_colon = (cur_prev2 == CH_COLON);
      entry.over_cur    = (cur_pos > byte_limit_ff);
      entry.over_prev   = (cur_pos_m1 > byte_limit_ff);

      byte_limit_in = csr_write_enable ? csr_write_data : byte_limit_ff;
      pos_in        = push ? sat16_add(cur_pos, 2'd1) : pos_ff;
      prev_in       = push ? data_byte : prev_ff;
      prev2_in      = push ? cur_prev : prev2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_limit_ff <= BYTE_LIMIT_RESET;
         pos_ff        <= 16'd0;
         prev_ff       <= 8'd0;
         prev2_ff      <= 8'd0;
      end else begin
         byte_limit_ff <= byte_limit_in;
         pos_ff        <= pos_in;
         prev_ff       <= prev_in;
         prev2_ff      <= prev2_in;
      end
   end

endmodule

### rtl/core/hrhc_fifo.sv
// Short queue of classified beats between the front end and the parser.
module hrhc_fifo #(
   parameter int DEPTH = hrhc_pkg::FIFO_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  hrhc_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output logic                not_empty,
   output hrhc_pkg::entry_type pop_entry
);
   import hrhc_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   entry_type         store_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full      = (count_ff == FULL_CNT);
   assign not_empty = (count_ff != '0);
   assign pop_entry = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### rtl/core/hrhc_back.sv
// Parser back end: per-request state machine and registered verdict output.
module hrhc_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       entry_valid,
   input  hrhc_pkg::entry_type        entry,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [hrhc_pkg::RSP_W-1:0] rsp_data
);
   import hrhc_pkg::*;

   typedef enum logic [1:0] {
      PH_LINE,
      PH_HEAD,
      PH_DONE
   } phase_type;

   typedef struct packed {
      logic [5:0]  cand;
      logic [3:0]  tok;
      logic        ver;
      logic        space;
      logic        malf;
      logic [4:0]  key;
      logic [30:0] len;
      logic [15:0] size;
   } pstate_type;

   localparam logic [4:0] KEY_LEN  = 5'd16;
   localparam logic [4:0] KEY_WS   = 5'd16;
   localparam logic [4:0] KEY_SIGN = 5'd17;
   localparam logic [4:0] KEY_DIG  = 5'd18;
   localparam logic [4:0] KEY_DEAD = 5'd31;
   localparam logic [30:0] LEN_MAX = 31'h7FFF_FFFF;
   localparam logic [30:0] LEN_THR_LO = 31'd214748364;
   localparam logic [30:0] LEN_THR_HI = 31'd214748363;

   localparam logic [63:0]  VER_STR = "HTTP/1.1";
   localparam logic [127:0] KEY_STR = "Content-Length: ";
   localparam logic [5:0][31:0] METH_STR = {
      {"put", 8'h00}, "head", {"get", 8'h00},
      {"PUT", 8'h00}, "HEAD", {"GET", 8'h00}
   };
   localparam logic [5:0][2:0] METH_LEN = {
      3'd3, 3'd4, 3'd3, 3'd3, 3'd4, 3'd3
   };
   localparam logic [5:0][1:0] METH_CODE = {
      METHOD_PUT, METHOD_HEAD, METHOD_GET, METHOD_PUT, METHOD_HEAD, METHOD_GET
   };

   localparam pstate_type PS_CLEAR = '{
      cand: 6'h3F, tok: 4'd0, ver: 1'b1, space: 1'b0, malf: 1'b0,
      key: 5'd0, len: 31'd0, size: 16'd0
   };

   function automatic pstate_type clear_line(pstate_type s);
      pstate_type r;
      r       = s;
      r.space = 1'b0;
      r.malf  = 1'b0;
      r.key   = 5'd0;
      r.tok   = 4'd0;
      return r;
   endfunction

   function automatic pstate_type req_step(pstate_type s, logic [7:0] b);
      pstate_type r;
      logic [5:0] keep;
      int         j;
      int         v;
      r      = s;
      keep   = '0;
      j      = int'(s.tok[1:0]);
      v      = int'(s.tok[2:0]);
      r.size = sat16_add(s.size, 2'd1);
      if (!s.space && (b == CH_SPACE)) begin
         for (int k = 0; k < 6; k++) begin
            keep[k] = ({1'b0, METH_LEN[k]} == s.tok);
         end
         r.cand  = s.cand & keep;
         r.space = 1'b1;
         r.tok   = 4'd0;
         r.ver   = 1'b1;
      end else if (s.space && (b == CH_SPACE)) begin
         r.tok = 4'd0;
         r.ver = 1'b1;
      end else begin
         if (!s.space) begin
            for (int k = 0; k < 6; k++) begin
               if ((s.tok >= {1'b0, METH_LEN[k]}) || (METH_STR[k][31-8*j -: 8] != b)) begin
                  r.cand[k] = 1'b0;
               end
            end
         end else if (s.tok[3] || (VER_STR[63-8*v -: 8] != b)) begin
            r.ver = 1'b0;
         end
         if (s.tok != 4'd15) begin
            r.tok = s.tok + 4'd1;
         end
      end
      return r;
   endfunction

   function automatic pstate_type head_step(pstate_type s, logic [7:0] b, logic prev_colon);
      pstate_type  r;
      logic [3:0]  d;
      logic [34:0] prod;
      logic        is_digit;
      logic        is_blank;
      int          ki;
      r        = s;
      d        = b[3:0];
      ki       = int'(s.key[3:0]);
      is_digit = (b >= 8'h30) && (b <= 8'h39);
      is_blank = (b == CH_SPACE) || ((b >= 8'd9) && (b <= 8'd13));
      prod     = ({4'b0, s.len} << 3) + ({4'b0, s.len} << 1) + {31'b0, d};
      r.size   = sat16_add(s.size, 2'd1);
      r.tok    = 4'd1;
      if ((b == CH_SPACE) && !s.space) begin
         r.space = 1'b1;
         if (!prev_colon) begin
            r.malf = 1'b1;
         end
      end
      if (s.key < KEY_LEN) begin
         if (b == KEY_STR[127-8*ki -: 8]) begin
            r.key = s.key + 5'd1;
            if (s.key == KEY_LEN - 5'd1) begin
               r.len = 31'd0;
            end
         end else begin
            r.key = KEY_DEAD;
         end
      end else if ((s.key == KEY_WS) || (s.key == KEY_SIGN) || (s.key == KEY_DIG)) begin
         if (is_digit) begin
            if (s.len > ((d <= 4'd7) ? LEN_THR_LO : LEN_THR_HI)) begin
               r.len = LEN_MAX;
            end else begin
               r.len = prod[30:0];
            end
            r.key = KEY_DIG;
         end else if ((s.key == KEY_WS) && is_blank) begin
            r.key = KEY_WS;
         end else if ((s.key == KEY_WS) && (b == CH_PLUS)) begin
            r.key = KEY_SIGN;
         end else begin
            r.key = KEY_DEAD;
         end
      end
      return r;
   endfunction

   phase_type   phase_ff, phase_in;
   pstate_type  ps_ff, ps_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;
   logic        verdict_valid;
   logic [1:0]  verdict;
   logic [1:0]  method;
   pstate_type  work;
   phase_type   ph;

   assign pop       = entry_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      work          = ps_ff;
      ph            = phase_ff;
      verdict_valid = 1'b0;
      verdict       = ST_OK;
      method        = METHOD_GET;
      if (pop) begin
         if (entry.frame_start) begin
            work = PS_CLEAR;
            ph   = PH_LINE;
         end
         unique case (ph)
            PH_LINE: begin
               if (entry.crlf) begin
                  work.size = sat16_add(work.size, 2'd2);
                  if (!work.space || !work.ver || (work.tok != 4'd8)) begin
                     verdict_valid = 1'b1;
                     verdict       = ST_BAD;
                  end else if (work.cand == 6'd0) begin
                     verdict_valid = 1'b1;
                     verdict       = ST_NIMP;
                  end else begin
                     ph   = PH_HEAD;
                     work = clear_line(work);
                  end
               end else begin
                  if (entry.prev_cr) begin
                     work = req_step(work, CH_CR);
                  end
                  if (entry.data_byte != CH_CR) begin
                     work = req_step(work, entry.data_byte);
                  end
               end
            end
            PH_HEAD: begin
               if (entry.crlf) begin
                  if (work.tok == 4'd0) begin
                     verdict_valid = 1'b1;
                     verdict       = ST_OK;
                  end else if (work.malf || !work.space) begin
                     verdict_valid = 1'b1;
                     verdict       = ST_BAD;
                  end else begin
                     work.size = sat16_add(work.size, 2'd2);
                     work      = clear_line(work);
                  end
               end else if (entry.prev_cr && entry.over_prev) begin
                  verdict_valid = 1'b1;
                  verdict       = ST_BAD;
               end else begin
                  if (entry.prev_cr) begin
                     work = head_step(work, CH_CR, entry.prev2_colon);
                  end
                  if (entry.data_byte != CH_CR) begin
                     if (entry.over_cur) begin
                        verdict_valid = 1'b1;
                        verdict       = ST_BAD;
                     end else begin
                        work = head_step(work, entry.data_byte, entry.prev_colon);
                     end
                  end
               end
            end
            default: begin
            end
         endcase
         if (verdict_valid) begin
            ph = PH_DONE;
         end
      end
      for (int k = 5; k >= 0; k--) begin
         if (work.cand[k]) begin
            method = METH_CODE[k];
         end
      end

      phase_in     = ph;
      ps_in        = work;
      rsp_valid_in = verdict_valid ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      rsp_data_in  = rsp_data_ff;
      if (verdict_valid) begin
         if (verdict == ST_OK) begin
            rsp_data_in = {5'd0, work.size, work.len, method, verdict};
         end else begin
            rsp_data_in = {54'd0, verdict};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_LINE;
         ps_ff        <= PS_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         ps_ff        <= ps_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

### rtl/core/http_request_head_checker.sv
// HTTP request head checker: byte stream in, one verdict beat per request out.
// Throughput: one byte beat per cycle while req_tready is high; the parser updates its state for each byte.
// A byte beat that decides a verdict is written into the four-entry queue, popped by the parser,
// and the verdict is registered in the output register that drives rsp_tvalid.
// Stalls: while a verdict beat waits, the parser holds, the queue fills and req_tready drops.
// Reset: synchronous, active high; clears parser, queue and output; byte_limit returns to 2045.
module http_request_head_checker #(
   parameter int FIFO_DEPTH = hrhc_pkg::FIFO_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tuser,   // frame_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata    // status, method_code, body_length, request_size
);
   import hrhc_pkg::*;

   entry_type push_entry;
   entry_type pop_entry;
   logic      fifo_full;
   logic      fifo_not_empty;
   logic      push;
   logic      pop;

   assign req_tready = !fifo_full;
   assign push       = req_tvalid && !fifo_full;

   hrhc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .data_byte        (req_tdata),
      .frame_start      (req_tuser),
      .push             (push),
      .entry            (push_entry)
   );

   hrhc_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (fifo_full),
      .pop        (pop),
      .not_empty  (fifo_not_empty),
      .pop_entry  (pop_entry)
   );

   hrhc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .entry_valid (fifo_not_empty),
      .entry       (pop_entry),
      .pop         (pop),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_data    (rsp_tdata)
   );

endmodule
